// File: sv/sarl_pkg.sv
// ----------------------------------------------------------------------------
// sarl_pkg: shared types and constants for the sorted address range lookup
// item layouts, operation and status codes, table sizing
// ----------------------------------------------------------------------------
package sarl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_BITS   = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SORT   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNSORTED  = 2'd3
  } status_t;

  typedef enum logic {
    REG_ADDR_OFFSET = 1'b0,
    REG_QUALITY     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [9:0]  entry_index;
    logic [47:0] entry_address;
    logic [47:0] routine_offset;
    logic [9:0]  removed_count;
    logic [10:0] entry_count;
  } out_item_t;

endpackage

// File: sv/sarl_mem.sv
// ----------------------------------------------------------------------------
// sarl_mem: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sarl_mem #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sorted_address_range_lookup_unit.sv
// ----------------------------------------------------------------------------
// sorted_address_range_lookup_unit: table of routine start addresses
// append, sort with duplicate removal, and range lookup by binary search
// ----------------------------------------------------------------------------
// The block holds up to 1024 routine start addresses in one memory with a
// single write and a single registered read port; every table access of a
// sort or lookup goes through that port under a small sequencer, and only one
// item is worked on at a time. An append or an item that needs no table walk
// answers in the cycle after acceptance. A lookup is a binary search over the n
// held entries, with one read and one compare per search step. A sort runs an
// insertion sort followed by one duplicate removal pass over the table. The
// next item is taken once the previous result has been taken.
// ----------------------------------------------------------------------------
module sorted_address_range_lookup_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sarl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sarl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [47:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,     // fetch the element to insert
    S_INS_V,      // latch it, fetch its left neighbour
    S_INS_CMP,    // shift neighbour right or drop the element in
    S_INS_PUT,    // element lands in slot zero
    S_DD_RD0,     // fetch first entry for duplicate removal
    S_DD_FIRST,   // latch first entry as last kept value
    S_DD_CMP,     // keep or skip each following entry
    S_SR_CHK,     // binary search: issue probe or finish
    S_SR_CMP      // binary search: narrow the window
  } state_t;

  localparam int IW = sarl_pkg::IDX_W;
  localparam int CW = sarl_pkg::CNT_W;
  localparam int AW = sarl_pkg::ADDR_BITS;

  state_t              state_r;
  sarl_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  // configuration
  logic [AW-1:0]       offset_r;
  logic [1:0]          quality_r;

  // table bookkeeping
  logic [CW-1:0]       held_r;
  logic                sorted_r;

  // sequencer working registers
  logic [CW-1:0]       i_r;      // insertion element index
  logic [CW-1:0]       j_r;      // insertion hole index
  logic [AW-1:0]       v_r;      // element being inserted
  logic [CW-1:0]       r_r;      // dedup read index
  logic [CW-1:0]       w_r;      // dedup write index
  logic [AW-1:0]       prev_r;   // last kept value
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       hi_r;
  logic [AW-1:0]       laddr_r;  // relocated probe address
  logic [AW-1:0]       start_r;  // last entry seen not above the probe

  // memory port
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_rdata;

  logic                in_acc;
  logic                tbl_full;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       j_m2;
  logic [CW-1:0]       r_p1;
  logic                rd_gt_v;
  logic                rd_new;
  logic [CW-1:0]       w_inc;
  sarl_pkg::out_item_t idle_res;  // result loaded when an item is taken

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tbl_full = (held_r == CW'(sarl_pkg::TABLE_DEPTH));
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign j_m2     = j_r - CW'(2);
  assign r_p1     = r_r + CW'(1);
  assign rd_gt_v  = (mem_rdata > v_r);
  assign rd_new   = (mem_rdata != prev_r);
  assign w_inc    = w_r + CW'(rd_new);

  sarl_mem #(
    .WIDTH (AW),
    .DEPTH (sarl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result for items answered straight away; a walk fills in the rest later
  always_comb begin
    idle_res             = '0;
    idle_res.entry_count = held_r;
    unique case (in_data.mode)
      sarl_pkg::MODE_APPEND: begin
        if (tbl_full) begin
          idle_res.status = sarl_pkg::ST_FULL;
        end else begin
          idle_res.entry_count = held_r + CW'(1);
        end
      end
      sarl_pkg::MODE_LOOKUP: begin
        if (!sorted_r || held_r == '0) begin
          idle_res.status = sarl_pkg::ST_UNSORTED;
        end else if (quality_r != '0) begin
          idle_res.status = sarl_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        idle_res.status = sarl_pkg::ST_OK;
      end
    endcase
  end

  // write port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = held_r[IW-1:0];
    mem_wdata = in_data.address;
    unique case (state_r)
      S_IDLE: begin
        mem_we = in_acc && (in_data.mode == sarl_pkg::MODE_APPEND) && !tbl_full;
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IW-1:0];
        mem_wdata = rd_gt_v ? mem_rdata : v_r;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = v_r;
      end
      S_DD_CMP: begin
        mem_we    = rd_new;
        mem_waddr = w_r[IW-1:0];
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // read port steering
  always_comb begin
    unique case (state_r)
      S_INS_RD:   mem_raddr = i_r[IW-1:0];
      S_INS_V:    mem_raddr = i_r[IW-1:0] - IW'(1);
      S_INS_CMP:  mem_raddr = j_m2[IW-1:0];
      S_DD_FIRST: mem_raddr = IW'(1);
      S_DD_CMP:   mem_raddr = r_p1[IW-1:0];
      S_SR_CHK:   mem_raddr = mid[IW-1:0];
      default:    mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      offset_r    <= '0;
      quality_r   <= '0;
      held_r      <= '0;
      sorted_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          sarl_pkg::REG_ADDR_OFFSET: offset_r  <= cfg_wdata;
          sarl_pkg::REG_QUALITY:     quality_r <= cfg_wdata[1:0];
          default:                   offset_r  <= offset_r;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_data_r <= idle_res;
            unique case (in_data.mode)
              sarl_pkg::MODE_APPEND: begin
                out_valid_r <= 1'b1;
                if (!tbl_full) begin
                  held_r   <= held_r + CW'(1);
                  sorted_r <= 1'b0;
                end
              end
              sarl_pkg::MODE_SORT: begin
                if (sorted_r || held_r == '0) begin
                  out_valid_r <= 1'b1;
                end else if (held_r == CW'(1)) begin
                  sorted_r    <= 1'b1;
                  out_valid_r <= 1'b1;
                end else begin
                  i_r     <= CW'(1);
                  state_r <= S_INS_RD;
                end
              end
              sarl_pkg::MODE_LOOKUP: begin
                if (!sorted_r || held_r == '0 || quality_r != '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  laddr_r <= in_data.address + offset_r;
                  lo_r    <= '0;
                  hi_r    <= held_r;
                  state_r <= S_SR_CHK;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end

        S_INS_RD: begin
          state_r <= S_INS_V;
        end

        S_INS_V: begin
          v_r     <= mem_rdata;
          j_r     <= i_r;
          state_r <= S_INS_CMP;
        end

        S_INS_CMP: begin
          if (rd_gt_v) begin
            // neighbour moved right, hole moves left
            j_r <= j_r - CW'(1);
            if (j_r == CW'(1)) begin
              state_r <= S_INS_PUT;
            end
          end else if (i_r + CW'(1) == held_r) begin
            state_r <= S_DD_RD0;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_INS_RD;
          end
        end

        S_INS_PUT: begin
          if (i_r + CW'(1) == held_r) begin
            state_r <= S_DD_RD0;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_INS_RD;
          end
        end

        S_DD_RD0: begin
          state_r <= S_DD_FIRST;
        end

        S_DD_FIRST: begin
          prev_r  <= mem_rdata;
          r_r     <= CW'(1);
          w_r     <= CW'(1);
          state_r <= S_DD_CMP;
        end

        S_DD_CMP: begin
          if (rd_new) begin
            prev_r <= mem_rdata;
          end
          w_r <= w_inc;
          r_r <= r_p1;
          if (r_p1 == held_r) begin
            held_r                   <= w_inc;
            sorted_r                 <= 1'b1;
            out_data_r.removed_count <= 10'(held_r - w_inc);
            out_data_r.entry_count   <= w_inc;
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end

        S_SR_CHK: begin
          if (lo_r < hi_r) begin
            state_r <= S_SR_CMP;
          end else begin
            // lo counts entries not above the probe
            if (lo_r == '0 || lo_r == held_r) begin
              out_data_r.status <= sarl_pkg::ST_NOT_FOUND;
            end else begin
              out_data_r.status         <= sarl_pkg::ST_OK;
              out_data_r.found          <= 1'b1;
              out_data_r.entry_index    <= 10'(lo_r - CW'(1));
              out_data_r.entry_address  <= start_r;
              out_data_r.routine_offset <= laddr_r - start_r;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        S_SR_CMP: begin
          if (mem_rdata <= laddr_r) begin
            lo_r    <= mid + CW'(1);
            start_r <= mem_rdata;
          end else begin
            hi_r <= mid;
          end
          state_r <= S_SR_CHK;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE) || out_valid_r)
    else $error("accepted item produced neither work nor a result");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(sarl_pkg::TABLE_DEPTH))
    else $error("held count above table depth");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.status == sarl_pkg::ST_OK)
    else $error("found result with non-ok status");

  a_search_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SR_CHK || state_r == S_SR_CMP) |-> sorted_r && (hi_r <= held_r))
    else $error("search running on unsorted table or bad window");
`endif

endmodule
